[sv/running_mean_variance_macros.svh]
// Assertion macros used by the checker of this project.
`ifndef RUNNING_MEAN_VARIANCE_MACROS_SVH
`define RUNNING_MEAN_VARIANCE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RMV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RMV_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/rmv_pkg.sv]
`default_nettype none
package rmv_pkg;

	localparam int DATA_W = 32;
	localparam int CNT_W = 16;
	localparam int SUM_W = 64;
	localparam int VAR_W = 48;
	localparam int FRAC_W = 16;
	localparam int ITER_W = 6;

	localparam int unsigned MAX_COUNT_DEF = 65535;
	localparam int SAMPLE_WIDTH_DEF = 32;

	// Iteration counts, loaded as count minus one.
	localparam logic [ITER_W-1:0] MDIV_LAST = ITER_W'(DATA_W);
	localparam logic [ITER_W-1:0] MUL_LAST = ITER_W'(DATA_W);
	localparam logic [ITER_W-1:0] VDIV_LAST = ITER_W'(SUM_W - 1);
	localparam logic [ITER_W-1:0] SQRT_LAST = ITER_W'(SUM_W / 2 - 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_MDIV,
		ST_MEAN,
		ST_MLOAD,
		ST_MUL,
		ST_SUM,
		ST_VLOAD,
		ST_VDIV,
		ST_SQLOAD,
		ST_SQRT,
		ST_FIN
	} ctrl_state_t;

	typedef struct packed {
		logic take;
		logic mdiv_load;
		logic div_step;
		logic mean_upd;
		logic mul_load;
		logic mul_step;
		logic sum_add;
		logic vdiv_load;
		logic var_load;
		logic sq_step;
		logic zero_res;
		logic out_load;
	} rmv_cmd_t;

	typedef struct packed {
		logic cnt_le1;
		logic out_free;
	} rmv_sts_t;

endpackage
`default_nettype wire

[sv/rmv_if.sv]
`default_nettype none
interface rmv_req_if import rmv_pkg::*; ();
	logic valid;
	logic ready;
	logic kind;
	logic signed [DATA_W-1:0] sample;

	modport source (output valid, kind, sample, input ready);
	modport sink (input valid, kind, sample, output ready);
endinterface

interface rmv_rsp_if import rmv_pkg::*; ();
	logic valid;
	logic ready;
	logic [CNT_W-1:0] count;
	logic signed [DATA_W-1:0] mean;
	logic [VAR_W-1:0] variance;
	logic [DATA_W-1:0] std_dev;

	modport source (output valid, count, mean, variance, std_dev, input ready);
	modport sink (input valid, count, mean, variance, std_dev, output ready);
endinterface
`default_nettype wire

[sv/rmv_ctrl.sv]
`default_nettype none
module rmv_ctrl import rmv_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	input  wire rmv_sts_t sts,
	output rmv_cmd_t      cmd
);

	ctrl_state_t state_q, state_d;
	logic [ITER_W-1:0] iter_q;
	logic last;

	assign last = (iter_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.mdiv_load) begin
				iter_q <= MDIV_LAST;
			end else if (cmd.mul_load) begin
				iter_q <= MUL_LAST;
			end else if (cmd.vdiv_load) begin
				iter_q <= VDIV_LAST;
			end else if (cmd.var_load) begin
				iter_q <= SQRT_LAST;
			end else if (cmd.div_step || cmd.mul_step || cmd.sq_step) begin
				iter_q <= iter_q - 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (req_valid) state_d = ST_DECIDE;
			ST_DECIDE: state_d = sts.cnt_le1 ? ST_FIN : ST_MDIV;
			ST_MDIV:   if (last) state_d = ST_MEAN;
			ST_MEAN:   state_d = ST_MLOAD;
			ST_MLOAD:  state_d = ST_MUL;
			ST_MUL:    if (last) state_d = ST_SUM;
			ST_SUM:    state_d = ST_VLOAD;
			ST_VLOAD:  state_d = ST_VDIV;
			ST_VDIV:   if (last) state_d = ST_SQLOAD;
			ST_SQLOAD: state_d = ST_SQRT;
			ST_SQRT:   if (last) state_d = ST_FIN;
			ST_FIN:    if (sts.out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.take = req_valid;
			end
			ST_DECIDE: begin
				cmd.zero_res = sts.cnt_le1;
				cmd.mdiv_load = !sts.cnt_le1;
			end
			ST_MDIV:   cmd.div_step = 1'b1;
			ST_MEAN:   cmd.mean_upd = 1'b1;
			ST_MLOAD:  cmd.mul_load = 1'b1;
			ST_MUL:    cmd.mul_step = 1'b1;
			ST_SUM:    cmd.sum_add = 1'b1;
			ST_VLOAD:  cmd.vdiv_load = 1'b1;
			ST_VDIV:   cmd.div_step = 1'b1;
			ST_SQLOAD: cmd.var_load = 1'b1;
			ST_SQRT:   cmd.sq_step = 1'b1;
			ST_FIN:    cmd.out_load = sts.out_free;
			default:   cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

[sv/rmv_dp.sv]
`default_nettype none
module rmv_dp import rmv_pkg::*; #(
	parameter int unsigned MAX_COUNT = MAX_COUNT_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire rmv_cmd_t                 cmd,
	output rmv_sts_t                      sts,
	input  wire logic                     req_kind,
	input  wire logic signed [DATA_W-1:0] req_sample,
	output logic                          rsp_valid,
	input  wire logic                     rsp_ready,
	output logic [CNT_W-1:0]              rsp_count,
	output logic signed [DATA_W-1:0]      rsp_mean,
	output logic [VAR_W-1:0]              rsp_variance,
	output logic [DATA_W-1:0]             rsp_std_dev
);

	localparam logic [CNT_W-1:0] CNT_LIMIT =
		(MAX_COUNT > ((1 << CNT_W) - 1)) ? {CNT_W{1'b1}} :
		(MAX_COUNT < 2) ? CNT_W'(2) : CNT_W'(MAX_COUNT);

	logic signed [SAMPLE_WIDTH-1:0] smp_trunc;
	logic signed [DATA_W-1:0] x_in;

	logic signed [DATA_W-1:0] x_q, mean_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] sum_q;

	logic neg_q;
	logic [CNT_W-1:0] rem_q, dvsr_q;
	logic [SUM_W-1:0] dvd_q;
	logic [SUM_W-1:0] mul_a_q, acc_q;
	logic [DATA_W:0] mul_b_q;
	logic [VAR_W-1:0] var_q;
	logic [SUM_W-1:0] sq_n_q, sq_res_q, sq_bit_q;
	logic rsp_valid_q;

	logic signed [DATA_W:0] dev_old, after, step, mean_sum;
	logic [DATA_W:0] before_mag, after_mag, quo;
	logic [CNT_W+1:0] trial;
	logic [SUM_W:0] sum_ext;
	logic [SUM_W-1:0] sq_t;

	assign smp_trunc = req_sample[SAMPLE_WIDTH-1:0];
	assign x_in = DATA_W'(smp_trunc);

	assign dev_old = {x_q[DATA_W-1], x_q} - {mean_q[DATA_W-1], mean_q};
	assign after = dev_old;
	assign before_mag = dev_old[DATA_W] ? -dev_old : dev_old;
	assign after_mag = after[DATA_W] ? -after : after;
	assign quo = dvd_q[DATA_W:0];
	assign step = neg_q ? -$signed(quo) : $signed(quo);
	assign mean_sum = {mean_q[DATA_W-1], mean_q} + step;
	assign trial = {1'b0, rem_q, dvd_q[SUM_W-1]} - {2'b00, dvsr_q};
	assign sum_ext = {1'b0, sum_q} + {1'b0, acc_q};
	assign sq_t = sq_res_q + sq_bit_q;

	assign sts.cnt_le1 = (cnt_q <= CNT_W'(1));
	assign sts.out_free = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;

	// Statistics state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			mean_q <= '0;
			sum_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				if (req_kind) begin
					cnt_q <= '0;
					mean_q <= '0;
					sum_q <= '0;
				end else begin
					if (cnt_q < CNT_LIMIT) cnt_q <= cnt_q + 1'b1;
					if (cnt_q == '0) begin
						mean_q <= x_in;
						sum_q <= '0;
					end
				end
			end
			if (cmd.mean_upd) mean_q <= mean_sum[DATA_W-1:0];
			if (cmd.sum_add) sum_q <= sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Shared divider, multiplier and square root working registers.
	always_ff @(posedge clk) begin
		if (cmd.take) x_q <= x_in;
		if (cmd.mdiv_load) begin
			dvd_q <= {before_mag, {(SUM_W-DATA_W-1){1'b0}}};
			dvsr_q <= cnt_q;
			rem_q <= '0;
			neg_q <= dev_old[DATA_W];
			mul_a_q <= SUM_W'(before_mag);
		end
		if (cmd.vdiv_load) begin
			dvd_q <= sum_q;
			dvsr_q <= cnt_q - 1'b1;
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			if (!trial[CNT_W+1]) begin
				rem_q <= trial[CNT_W-1:0];
				dvd_q <= {dvd_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[CNT_W-2:0], dvd_q[SUM_W-1]};
				dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
			end
		end
		if (cmd.mul_load) begin
			mul_b_q <= after_mag;
			acc_q <= '0;
		end
		if (cmd.mul_step) begin
			if (mul_b_q[0]) acc_q <= acc_q + mul_a_q;
			mul_a_q <= {mul_a_q[SUM_W-2:0], 1'b0};
			mul_b_q <= {1'b0, mul_b_q[DATA_W:1]};
		end
		if (cmd.var_load) begin
			var_q <= dvd_q[SUM_W-1:FRAC_W];
			sq_n_q <= {dvd_q[SUM_W-1:FRAC_W], {FRAC_W{1'b0}}};
			sq_res_q <= '0;
			sq_bit_q <= {2'b01, {(SUM_W-2){1'b0}}};
		end
		if (cmd.sq_step) begin
			if (sq_n_q >= sq_t) begin
				sq_n_q <= sq_n_q - sq_t;
				sq_res_q <= {1'b0, sq_res_q[SUM_W-1:1]} + sq_bit_q;
			end else begin
				sq_res_q <= {1'b0, sq_res_q[SUM_W-1:1]};
			end
			sq_bit_q <= {2'b00, sq_bit_q[SUM_W-1:2]};
		end
		if (cmd.zero_res) begin
			var_q <= '0;
			sq_res_q <= '0;
		end
		if (cmd.out_load) begin
			rsp_count <= cnt_q;
			rsp_mean <= (cnt_q == '0) ? '0 : mean_q;
			rsp_variance <= var_q;
			rsp_std_dev <= sq_res_q[DATA_W-1:0];
		end
	end

endmodule
`default_nettype wire

[sv/running_mean_variance.sv]
// A clear, or the first sample after a clear, goes straight from the decision state to the result;
// any later sample first runs the full arithmetic sequence. Either may wait for the result register to drain.
// A new request is not taken until the last one is through the shared bit-serial divider (33 and
// 64 steps), the bit-serial multiplier (33 steps) and the square root (32 steps).
// Reset (arst_n low, asynchronous): count, mean and sum go to zero, no result is pending.
`default_nettype none
module running_mean_variance import rmv_pkg::*; #(
	parameter int unsigned MAX_COUNT = MAX_COUNT_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	rmv_req_if.sink  req,
	rmv_rsp_if.source rsp
);

	// The controller steps through one request at a time: it takes the request, runs the
	// mean division, the deviation product, the variance division and the square root when
	// more than one sample is held, and then parks the result in the output register. A new
	// request is taken as soon as the result is loaded, even if the sink has not yet taken it.
	rmv_cmd_t cmd;
	rmv_sts_t sts;

	rmv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the statistics and the shared arithmetic units.
	rmv_dp #(
		.MAX_COUNT    (MAX_COUNT),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_kind     (req.kind),
		.req_sample   (req.sample),
		.rsp_valid    (rsp.valid),
		.rsp_ready    (rsp.ready),
		.rsp_count    (rsp.count),
		.rsp_mean     (rsp.mean),
		.rsp_variance (rsp.variance),
		.rsp_std_dev  (rsp.std_dev)
	);

endmodule
`default_nettype wire

[sv/rmv_checker.sv]
`default_nettype none
`include "running_mean_variance_macros.svh"
module rmv_checker import rmv_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              req_valid,
	input wire logic              req_ready,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire logic [CNT_W-1:0]  rsp_count,
	input wire logic [DATA_W-1:0] rsp_mean,
	input wire logic [VAR_W-1:0]  rsp_variance,
	input wire logic [DATA_W-1:0] rsp_std_dev
);

	`RMV_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid, "result dropped")
	`RMV_ASSERT_NXT(a_busy, clk, arst_n, req_valid && req_ready, !req_ready, "request taken while busy")
	`RMV_ASSERT_IMP(a_var_small, clk, arst_n, rsp_valid && rsp_count < 2,
		rsp_variance == '0 && rsp_std_dev == '0, "variance below two samples")
	`RMV_ASSERT_IMP(a_mean_empty, clk, arst_n, rsp_valid && rsp_count == '0,
		rsp_mean == '0, "mean not zero when empty")

endmodule

bind running_mean_variance rmv_checker u_rmv_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_count    (rsp.count),
	.rsp_mean     (rsp.mean),
	.rsp_variance (rsp.variance),
	.rsp_std_dev  (rsp.std_dev)
);
`default_nettype wire

[verif/running_mean_variance_test.sv]
`default_nettype none
module running_mean_variance_test import rmv_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// Request kinds. Only bit 0 of the kind field is looked at by the block.
	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	// Number of random requests that follow the directed table.
	localparam int RANDOM_REQUESTS = 1030;
	// The last requests run with no idling on either side.
	localparam int QUIET_TAIL = 120;
	// The receiver holds off once for this many cycles after this many results.
	localparam int LONG_HOLD = 700;
	localparam int HOLD_AFTER = 150;
	// The sender waits for every outstanding result at this random request.
	localparam int DRAIN_AT = 500;
	// Cycles without any handshake before the run is declared hung. A correct block needs
	// at most one full arithmetic sequence per request plus the long hold.
	localparam int HANG_LIMIT = 20000;
	// Cycles allowed after the last result for stray results to show up.
	localparam int SETTLE_CYCLES = 400;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic signed [DATA_W-1:0] mean;
		logic [VAR_W-1:0] variance;
		logic [DATA_W-1:0] std_dev;
	} stats_t;

	typedef struct {
		logic kind;
		logic [DATA_W-1:0] sample;
		bit typed;
		stats_t want;
	} plan_row_t;

	localparam stats_t EMPTY_STATS = '0;

	logic clk;
	logic arst_n;

	rmv_req_if req ();
	rmv_rsp_if rsp ();

	running_mean_variance uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	always #4 clk = ~clk;

	// Model state: sample count, Q16.16 mean and Q32.32 sum of squared deviations.
	logic [CNT_W-1:0] model_count;
	longint model_mean;
	logic [SUM_W-1:0] model_sum;

	// Statistics the block still owes, oldest first.
	stats_t pending_stats[$];

	int errors;
	int results_seen;
	bit quiet;
	int idle_cycles;

	function automatic logic [SUM_W-1:0] floor_root(input logic [SUM_W-1:0] n);
		logic [SUM_W-1:0] root;
		logic [SUM_W-1:0] bitv;
		root = '0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n = n - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic logic [SUM_W-1:0] magnitude(input longint v);
		return v < 0 ? SUM_W'(-v) : SUM_W'(v);
	endfunction

	// Applies one request to the model state and returns the statistics after it.
	function automatic stats_t welford_update(input logic kind, input logic [DATA_W-1:0] sample);
		stats_t r;
		longint x;
		longint dev_old;
		longint dev_new;
		logic [SUM_W-1:0] prod;
		logic [SUM_W-1:0] quot;
		x = longint'($signed(sample));
		if (kind == KIND_CLEAR) begin
			model_count = '0;
			model_mean = 0;
			model_sum = '0;
		end else begin
			if (model_count < 16'hFFFF)
				model_count = model_count + 1'b1;
			if (model_count == 1) begin
				model_mean = x;
				model_sum = '0;
			end else begin
				// Division by the count truncates toward zero, as in the block.
				dev_old = x - model_mean;
				model_mean = model_mean + dev_old / longint'(model_count);
				dev_new = x - model_mean;
				prod = magnitude(dev_old) * magnitude(dev_new);
				if (model_sum > ~prod)
					model_sum = '1;
				else
					model_sum = model_sum + prod;
			end
		end
		r = EMPTY_STATS;
		r.count = model_count;
		if (model_count > 0)
			r.mean = model_mean[DATA_W-1:0];
		if (model_count > 1) begin
			quot = (model_sum / SUM_W'(model_count - 1)) >> FRAC_W;
			if (quot > 64'hFFFF_FFFF_FFFF)
				quot = 64'hFFFF_FFFF_FFFF;
			r.variance = quot[VAR_W-1:0];
			r.std_dev = DATA_W'(floor_root(quot << FRAC_W));
		end
		return r;
	endfunction

	// Offers one request and waits for the block to take it. A short idle
	// burst is inserted at random in front of it, except in the quiet tail.
	task automatic send_request(input logic kind, input logic [DATA_W-1:0] sample,
			input bit typed, input stats_t want);
		stats_t predicted;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.kind <= kind;
		req.sample <= sample;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		predicted = welford_update(kind, sample);
		// Rows of the directed table with a typed answer are checked against it.
		pending_stats.push_back(typed ? want : predicted);
	endtask

	function automatic logic [DATA_W-1:0] random_sample();
		case ($urandom_range(0, 4))
			0: return $urandom();
			// Small values around zero, a few units in Q16.16.
			1: return DATA_W'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
			// Values close to the current mean so the deviations stay tiny.
			2: return model_mean[DATA_W-1:0] + DATA_W'($urandom_range(0, 64)) - 32'd32;
			3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom())};
		endcase
	endfunction

	// Result side: check every accepted result and pace the ready signal.
	initial begin
		int off_cycles;
		bit held;
		stats_t want;
		off_cycles = 0;
		held = 1'b0;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				results_seen++;
				if (pending_stats.size() == 0) begin
					errors++;
					$error("result with nothing outstanding: count %0d", rsp.count);
				end else begin
					want = pending_stats.pop_front();
					if (rsp.count !== want.count) begin
						errors++;
						$error("count: expected %0d, actual %0d", want.count, rsp.count);
					end
					if (rsp.mean !== want.mean) begin
						errors++;
						$error("mean: expected %h, actual %h", want.mean, rsp.mean);
					end
					if (rsp.variance !== want.variance) begin
						errors++;
						$error("variance: expected %h, actual %h", want.variance,
							rsp.variance);
					end
					if (rsp.std_dev !== want.std_dev) begin
						errors++;
						$error("std_dev: expected %h, actual %h", want.std_dev, rsp.std_dev);
					end
				end
			end
			// One long hold-off lets the block fill up and stall its input while the
			// sender keeps offering requests; otherwise only short random stalls.
			if (!held && results_seen >= HOLD_AFTER) begin
				held = 1'b1;
				off_cycles = LONG_HOLD;
			end else if (off_cycles == 0 && !quiet && $urandom_range(0, 7) == 0) begin
				off_cycles = $urandom_range(1, 3);
			end
			if (off_cycles > 0) begin
				off_cycles--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// Watchdog: any cycle with a handshake on either side counts as progress.
	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= HANG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Request side: directed table first, then random requests.
	initial begin
		plan_row_t plan[18];
		int settle;
		plan = '{
			// Clearing right after reset shows all zeros.
			'{KIND_CLEAR, 32'h1234_5678, 1'b1, EMPTY_STATS},
			// The first sample sets the mean; nothing to divide yet.
			'{KIND_PUSH, 32'h7FFF_FFFF, 1'b1, '{16'd1, 32'h7FFF_FFFF, 48'd0, 32'd0}},
			// Alternating extremes drive the sum of squared deviations into saturation.
			'{KIND_PUSH, 32'h8000_0000, 1'b0, EMPTY_STATS},
			'{KIND_PUSH, 32'h7FFF_FFFF, 1'b0, EMPTY_STATS},
			'{KIND_PUSH, 32'h8000_0000, 1'b0, EMPTY_STATS},
			'{KIND_PUSH, 32'h7FFF_FFFF, 1'b0, EMPTY_STATS},
			'{KIND_PUSH, 32'h8000_0000, 1'b0, EMPTY_STATS},
			'{KIND_PUSH, 32'h7FFF_FFFF, 1'b0, EMPTY_STATS},
			'{KIND_CLEAR, 32'hFFFF_FFFF, 1'b1, EMPTY_STATS},
			'{KIND_PUSH, 32'h8000_0000, 1'b1, '{16'd1, 32'h8000_0000, 48'd0, 32'd0}},
			// Two equal samples leave the variance at zero.
			'{KIND_PUSH, 32'h8000_0000, 1'b1, '{16'd2, 32'h8000_0000, 48'd0, 32'd0}},
			'{KIND_PUSH, 32'h0000_0000, 1'b0, EMPTY_STATS},
			'{KIND_PUSH, 32'h0000_0001, 1'b0, EMPTY_STATS},
			'{KIND_PUSH, 32'hFFFF_FFFF, 1'b0, EMPTY_STATS},
			'{KIND_CLEAR, 32'h0000_0000, 1'b1, EMPTY_STATS},
			'{KIND_PUSH, 32'h0001_0000, 1'b1, '{16'd1, 32'h0001_0000, 48'd0, 32'd0}},
			// Samples 1.0 and 3.0 give mean 2.0 and variance 2.0.
			'{KIND_PUSH, 32'h0003_0000, 1'b1,
				'{16'd2, 32'h0002_0000, 48'h0000_0002_0000, 32'd92681}},
			'{KIND_PUSH, 32'hFFFE_0000, 1'b0, EMPTY_STATS}
		};
		errors = 0;
		results_seen = 0;
		quiet = 1'b0;
		model_count = '0;
		model_mean = 0;
		model_sum = '0;
		clk = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.kind = KIND_PUSH;
		req.sample = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_request(plan[i].kind, plan[i].sample, plan[i].typed, plan[i].want);

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n == DRAIN_AT) begin
				// Let the block run dry before offering anything more.
				req.valid <= 1'b0;
				@(posedge clk);
				while (pending_stats.size() != 0)
					@(posedge clk);
			end
			if (n == RANDOM_REQUESTS - QUIET_TAIL)
				quiet = 1'b1;
			// Mostly sample runs with random content, now and then a clear.
			if ($urandom_range(0, 39) == 0)
				send_request(KIND_CLEAR, $urandom(), 1'b0, EMPTY_STATS);
			else
				send_request(KIND_PUSH, random_sample(), 1'b0, EMPTY_STATS);
		end
		req.valid <= 1'b0;

		while (pending_stats.size() != 0)
			@(posedge clk);
		settle = 0;
		while (settle < SETTLE_CYCLES) begin
			@(posedge clk);
			settle++;
		end
		if (errors == 0 && pending_stats.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire
